>>> hw/rtl/grid_bfs_shortest_path_assert.svh
// Assertion macros for the checker of the grid search block.
`ifndef GRID_BFS_SHORTEST_PATH_ASSERT_SVH
`define GRID_BFS_SHORTEST_PATH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBSP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("grid search check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define GBSP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("grid search check failed in the following cycle");

`endif

>>> hw/rtl/gbsp_pkg.sv
// Package of shared types and constants for the grid search block.
package gbsp_pkg;

   // Result and register widths.
   localparam int LEN_W = 14;
   localparam logic [LEN_W-1:0] LEN_MAX = 14'h3fff;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_DATA_W-1:0] DIM_RESET = 8'd128;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_ROWS = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLS = 4'd1;

   // Cell codes of an incoming item.
   typedef enum logic [1:0] {
      KIND_OPEN  = 2'd0,
      KIND_WALL  = 2'd1,
      KIND_START = 2'd2,
      KIND_GOAL  = 2'd3
   } cell_kind_type;

   // Neighbour directions in the order they are tried.
   typedef enum logic [1:0] {
      DIR_DOWN  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_UP    = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

endpackage

>>> hw/rtl/gbsp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module gbsp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hw/rtl/gbsp_nbr.sv
// Shared neighbour step unit: bounds check and address of one neighbour.
module gbsp_nbr #(
   parameter int MAX_DIM = 128
) (
   input  gbsp_pkg::dir_type                         dir,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        cur_idx,
   input  logic [$clog2(MAX_DIM)-1:0]                cur_row,
   input  logic [$clog2(MAX_DIM)-1:0]                cur_col,
   input  logic [$clog2(MAX_DIM+1)-1:0]              row_count,
   input  logic [$clog2(MAX_DIM+1)-1:0]              col_count,
   output logic                                      nbr_ok,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        nbr_idx,
   output logic [$clog2(MAX_DIM)-1:0]                nbr_row,
   output logic [$clog2(MAX_DIM)-1:0]                nbr_col
);
   import gbsp_pkg::*;

   localparam int IDX_W  = $clog2(MAX_DIM*MAX_DIM);
   localparam int DIM_W  = $clog2(MAX_DIM);
   localparam int DIMC_W = $clog2(MAX_DIM+1);

   logic              step_row;
   logic              step_back;
   logic [IDX_W-1:0]  addend;
   logic [DIMC_W-1:0] row_up;
   logic [DIMC_W-1:0] col_up;

   // One adder serves all four directions: a row step moves by the column count.
   assign step_row  = (dir == DIR_DOWN) || (dir == DIR_UP);
   assign step_back = (dir == DIR_UP) || (dir == DIR_LEFT);
   assign addend    = step_row ? IDX_W'(col_count) : IDX_W'(1);
   assign nbr_idx   = step_back ? (cur_idx - addend) : (cur_idx + addend);

   assign row_up = DIMC_W'(cur_row) + DIMC_W'(1);
   assign col_up = DIMC_W'(cur_col) + DIMC_W'(1);

   // Bounds check and new coordinates for the chosen direction.
   always_comb begin
      unique case (dir)
         DIR_DOWN: begin
            nbr_ok  = row_up < row_count;
            nbr_row = DIM_W'(row_up);
            nbr_col = cur_col;
         end
         DIR_RIGHT: begin
            nbr_ok  = col_up < col_count;
            nbr_row = cur_row;
            nbr_col = DIM_W'(col_up);
         end
         DIR_UP: begin
            nbr_ok  = cur_row != '0;
            nbr_row = cur_row - DIM_W'(1);
            nbr_col = cur_col;
         end
         DIR_LEFT: begin
            nbr_ok  = cur_col != '0;
            nbr_row = cur_row;
            nbr_col = cur_col - DIM_W'(1);
         end
      endcase
   end

endmodule

>>> hw/rtl/grid_bfs_shortest_path.sv
// Top level of the grid shortest-path search block: loader, sequencer and memories.
//
// Usage: the maze arrives on the req_ channel one cell per item in row-major
// order, cell_kind giving open, wall, start or goal. While loading, one item is
// taken every cycle. The item with last_cell set ends the grid and starts the
// search; req_stall stays high until the search has finished.
// A search first sweeps the visited map over rows*cols cells (one per cycle),
// then runs a breadth-first search: each dequeued cell goes through the states
// DEQ, HEAD, NBR once per neighbour and DRAIN, using one neighbour step unit;
// the wall and visited memories are read once per neighbour.
// If no start or goal was loaded the sweep is skipped and the answer is
// delivered from the FINISH state.
// The result (path_length, reachable) sits in an output register on the rsp_
// channel until taken; loading of the next grid may go on meanwhile, and a
// further search waits before delivering until that register is free.
// Rows and columns are written on the csr_ port, index 0 and 1; the user must
// write them only when idle, as the block does not enforce it. Reset clears the
// counters, sets rows and columns to 128 and leaves the memory contents as they are.
module grid_bfs_shortest_path #(
   parameter int MAX_DIM = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_cell_kind,
   input  logic                               req_last_cell,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [gbsp_pkg::LEN_W-1:0]         rsp_path_length,
   output logic                               rsp_reachable,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gbsp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gbsp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gbsp_pkg::*;

   localparam int CELL_COUNT = MAX_DIM * MAX_DIM;
   localparam int IDX_W      = $clog2(CELL_COUNT);
   localparam int CNT_W      = IDX_W + 1;
   localparam int DIM_W      = $clog2(MAX_DIM);
   localparam int DIMC_W     = $clog2(MAX_DIM + 1);
   localparam int QW         = LEN_W + 2 * DIM_W + IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_SEED, ST_DEQ, ST_HEAD, ST_NBR, ST_DRAIN, ST_FINISH
   } state_type;

   // Clamp a dimension register into 1..MAX_DIM.
   function automatic logic [DIMC_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v);
      logic [DIMC_W+CSR_DATA_W-1:0] wide;
      wide = (DIMC_W + CSR_DATA_W)'(v);
      if (v == '0) begin
         return DIMC_W'(1);
      end else if (wide > (DIMC_W + CSR_DATA_W)'(MAX_DIM)) begin
         return DIMC_W'(MAX_DIM);
      end else begin
         return DIMC_W'(v);
      end
   endfunction

   state_type state_ff, state_in;
   logic [CSR_DATA_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [CNT_W-1:0]      load_pos_ff, load_pos_in;
   logic [CNT_W-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [IDX_W-1:0]      start_idx_ff, start_idx_in, goal_idx_ff, goal_idx_in;
   logic                  start_seen_ff, start_seen_in, goal_seen_ff, goal_seen_in;
   logic [IDX_W-1:0]      sweep_ff, sweep_in;
   logic [DIM_W-1:0]      sweep_row_ff, sweep_row_in, sweep_col_ff, sweep_col_in;
   logic [DIM_W-1:0]      start_row_ff, start_row_in, start_col_ff, start_col_in;
   logic [IDX_W-1:0]      cur_idx_ff, cur_idx_in, pend_idx_ff, pend_idx_in;
   logic [DIM_W-1:0]      cur_row_ff, cur_row_in, cur_col_ff, cur_col_in;
   logic [DIM_W-1:0]      pend_row_ff, pend_row_in, pend_col_ff, pend_col_in;
   logic [LEN_W-1:0]      cur_dist_ff, cur_dist_in;
   logic                  pend_valid_ff, pend_valid_in;
   dir_type               dir_ff, dir_in;
   logic [LEN_W-1:0]      res_len_ff, res_len_in, rsp_len_ff, rsp_len_in;
   logic                  res_ok_ff, res_ok_in, rsp_ok_ff, rsp_ok_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [DIMC_W-1:0]     r_eff, c_eff;
   logic [2*DIMC_W-1:0]   cell_prod;
   logic [CNT_W-1:0]      cell_total;
   logic                  req_take, load_in_grid, load_full, ends_ok;
   logic [LEN_W-1:0]      next_dist;

   logic                  wall_we, wall_wdata, wall_re, wall_rdata;
   logic [IDX_W-1:0]      wall_waddr;
   logic                  vis_we, vis_wdata, vis_re, vis_rdata;
   logic [IDX_W-1:0]      vis_waddr;
   logic                  q_we, q_re;
   logic [IDX_W-1:0]      q_waddr;
   logic [QW-1:0]         q_wdata, q_rdata;
   logic [IDX_W-1:0]      q_idx;
   logic [DIM_W-1:0]      q_row, q_col;
   logic [LEN_W-1:0]      q_dist;

   logic                  nbr_ok;
   logic [IDX_W-1:0]      nbr_idx;
   logic [DIM_W-1:0]      nbr_row, nbr_col;

   // Effective grid size from the registers.
   assign r_eff      = clamp_dim(rows_ff);
   assign c_eff      = clamp_dim(cols_ff);
   assign cell_prod  = r_eff * c_eff;
   assign cell_total = CNT_W'(cell_prod);

   assign req_take     = req_valid && !req_stall;
   assign load_in_grid = load_pos_ff < cell_total;
   assign load_full    = load_pos_ff == CNT_W'(CELL_COUNT);
   assign next_dist    = (cur_dist_ff == LEN_MAX) ? LEN_MAX : cur_dist_ff + LEN_W'(1);

   // Queue entry layout: distance, row, column, cell index.
   assign q_idx  = q_rdata[IDX_W-1:0];
   assign q_col  = q_rdata[IDX_W+DIM_W-1:IDX_W];
   assign q_row  = q_rdata[IDX_W+2*DIM_W-1:IDX_W+DIM_W];
   assign q_dist = q_rdata[QW-1:IDX_W+2*DIM_W];

   // Port outputs.
   assign req_stall       = state_ff != ST_IDLE;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_reachable   = rsp_ok_ff;

   // Neighbour step unit working on the current cell.
   gbsp_nbr #(.MAX_DIM(MAX_DIM)) u_nbr (
      .dir       (dir_ff),
      .cur_idx   (cur_idx_ff),
      .cur_row   (cur_row_ff),
      .cur_col   (cur_col_ff),
      .row_count (r_eff),
      .col_count (c_eff),
      .nbr_ok    (nbr_ok),
      .nbr_idx   (nbr_idx),
      .nbr_row   (nbr_row),
      .nbr_col   (nbr_col)
   );

   // Wall map, visited map and frontier queue.
   gbsp_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_wall_ram (
      .clock   (clock),
      .wr_en   (wall_we),
      .wr_addr (wall_waddr),
      .wr_data (wall_wdata),
      .rd_en   (wall_re),
      .rd_addr (nbr_idx),
      .rd_data (wall_rdata)
   );

   gbsp_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_vis_ram (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_waddr),
      .wr_data (vis_wdata),
      .rd_en   (vis_re),
      .rd_addr (nbr_idx),
      .rd_data (vis_rdata)
   );

   gbsp_ram #(.WIDTH(QW), .DEPTH(CELL_COUNT)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (q_rdata)
   );

   // Sequencer: loading, visited sweep, and the search loop.
   always_comb begin
      state_in      = state_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      load_pos_in   = load_pos_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      start_idx_in  = start_idx_ff;
      goal_idx_in   = goal_idx_ff;
      start_seen_in = start_seen_ff;
      goal_seen_in  = goal_seen_ff;
      sweep_in      = sweep_ff;
      sweep_row_in  = sweep_row_ff;
      sweep_col_in  = sweep_col_ff;
      start_row_in  = start_row_ff;
      start_col_in  = start_col_ff;
      cur_idx_in    = cur_idx_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      cur_dist_in   = cur_dist_ff;
      pend_idx_in   = pend_idx_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      pend_valid_in = pend_valid_ff;
      dir_in        = dir_ff;
      res_len_in    = res_len_ff;
      res_ok_in     = res_ok_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_valid_in  = rsp_valid_ff;
      ends_ok       = 1'b0;

      wall_we    = 1'b0;
      wall_waddr = load_pos_ff[IDX_W-1:0];
      wall_wdata = req_cell_kind == KIND_WALL;
      wall_re    = 1'b0;
      vis_we     = 1'b0;
      vis_waddr  = sweep_ff;
      vis_wdata  = 1'b0;
      vis_re     = 1'b0;
      q_we       = 1'b0;
      q_waddr    = tail_ff[IDX_W-1:0];
      q_wdata    = {next_dist, pend_row_ff, pend_col_ff, pend_idx_ff};
      q_re       = 1'b0;

      // Configuration writes.
      if (csr_valid && csr_ready) begin
         unique case (csr_addr)
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
            default:  ;
         endcase
      end

      // The output register empties when its item is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // A neighbour read in the previous cycle is entered if free and open.
      if ((state_ff == ST_NBR || state_ff == ST_DRAIN) && pend_valid_ff
          && !wall_rdata && !vis_rdata) begin
         vis_we    = 1'b1;
         vis_waddr = pend_idx_ff;
         vis_wdata = 1'b1;
         q_we      = 1'b1;
         tail_in   = tail_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (load_in_grid) begin
                  wall_we = 1'b1;
                  if (req_cell_kind == KIND_START) begin
                     start_idx_in  = load_pos_ff[IDX_W-1:0];
                     start_seen_in = 1'b1;
                  end
                  if (req_cell_kind == KIND_GOAL) begin
                     goal_idx_in  = load_pos_ff[IDX_W-1:0];
                     goal_seen_in = 1'b1;
                  end
               end
               if (!load_full) begin
                  load_pos_in = load_pos_ff + CNT_W'(1);
               end
               if (req_last_cell) begin
                  ends_ok = start_seen_in && goal_seen_in
                            && (CNT_W'(start_idx_in) < cell_total)
                            && (CNT_W'(goal_idx_in) < cell_total);
                  load_pos_in   = '0;
                  start_seen_in = 1'b0;
                  goal_seen_in  = 1'b0;
                  sweep_in      = '0;
                  sweep_row_in  = '0;
                  sweep_col_in  = '0;
                  res_len_in    = '0;
                  res_ok_in     = 1'b0;
                  state_in      = ends_ok ? ST_CLEAR : ST_FINISH;
               end
            end
         end
         ST_CLEAR: begin
            // Clear one visited entry and find the start coordinates on the way.
            vis_we = 1'b1;
            if (sweep_ff == start_idx_ff) begin
               start_row_in = sweep_row_ff;
               start_col_in = sweep_col_ff;
            end
            if (CNT_W'(sweep_ff) == cell_total - CNT_W'(1)) begin
               state_in = ST_SEED;
            end else begin
               sweep_in = sweep_ff + IDX_W'(1);
               if (DIMC_W'(sweep_col_ff) + DIMC_W'(1) == c_eff) begin
                  sweep_col_in = '0;
                  sweep_row_in = sweep_row_ff + DIM_W'(1);
               end else begin
                  sweep_col_in = sweep_col_ff + DIM_W'(1);
               end
            end
         end
         ST_SEED: begin
            vis_we    = 1'b1;
            vis_waddr = start_idx_ff;
            vis_wdata = 1'b1;
            q_we      = 1'b1;
            q_waddr   = '0;
            q_wdata   = {LEN_W'(0), start_row_ff, start_col_ff, start_idx_ff};
            head_in   = '0;
            tail_in   = CNT_W'(1);
            state_in  = ST_DEQ;
         end
         ST_DEQ: begin
            if (head_ff == tail_ff) begin
               res_len_in = '0;
               res_ok_in  = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               q_re     = 1'b1;
               head_in  = head_ff + CNT_W'(1);
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (q_idx == goal_idx_ff) begin
               res_len_in = q_dist;
               res_ok_in  = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cur_idx_in    = q_idx;
               cur_row_in    = q_row;
               cur_col_in    = q_col;
               cur_dist_in   = q_dist;
               dir_in        = DIR_DOWN;
               pend_valid_in = 1'b0;
               state_in      = ST_NBR;
            end
         end
         ST_NBR: begin
            // Issue the memory reads for one neighbour per cycle.
            wall_re       = 1'b1;
            vis_re        = 1'b1;
            pend_valid_in = nbr_ok;
            pend_idx_in   = nbr_idx;
            pend_row_in   = nbr_row;
            pend_col_in   = nbr_col;
            dir_in        = dir_type'(dir_ff + 2'd1);
            if (dir_ff == DIR_LEFT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            pend_valid_in = 1'b0;
            state_in      = ST_DEQ;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = res_len_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   // State, control and payload registers.
   always_ff @(posedge clock) begin
      start_idx_ff <= start_idx_in;
      goal_idx_ff  <= goal_idx_in;
      sweep_ff     <= sweep_in;
      sweep_row_ff <= sweep_row_in;
      sweep_col_ff <= sweep_col_in;
      start_row_ff <= start_row_in;
      start_col_ff <= start_col_in;
      cur_idx_ff   <= cur_idx_in;
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      cur_dist_ff  <= cur_dist_in;
      pend_idx_ff  <= pend_idx_in;
      pend_row_ff  <= pend_row_in;
      pend_col_ff  <= pend_col_in;
      res_len_ff   <= res_len_in;
      res_ok_ff    <= res_ok_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_ok_ff    <= rsp_ok_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         rows_ff       <= DIM_RESET;
         cols_ff       <= DIM_RESET;
         load_pos_ff   <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         start_seen_ff <= 1'b0;
         goal_seen_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         dir_ff        <= DIR_DOWN;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         load_pos_ff   <= load_pos_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         start_seen_ff <= start_seen_in;
         goal_seen_ff  <= goal_seen_in;
         pend_valid_ff <= pend_valid_in;
         dir_ff        <= dir_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/gbsp_checker.sv
// Port-level checker for the grid search block, bound to the top level.
`include "grid_bfs_shortest_path_assert.svh"

module gbsp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_last_cell,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [gbsp_pkg::LEN_W-1:0] rsp_path_length,
   input logic                       rsp_reachable
);

   // A stalled result item holds its value.
   `GBSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_path_length) && $stable(rsp_reachable))

   // An unreachable goal always reports a length of zero.
   `GBSP_ASSERT_SAME(a_unreach_zero, rsp_valid && !rsp_reachable, rsp_path_length == '0)

   // The last cell of a grid starts a search, so the input stalls next.
   `GBSP_ASSERT_NEXT(a_last_stalls, req_valid && !req_stall && req_last_cell, req_stall)

   // Ordinary cells keep the input open.
   `GBSP_ASSERT_NEXT(a_load_open, req_valid && !req_stall && !req_last_cell, !req_stall)

   // A new result only appears at the end of a search.
   `GBSP_ASSERT_SAME(a_rsp_after_search, $rose(rsp_valid), $past(req_stall))

endmodule

bind grid_bfs_shortest_path gbsp_checker u_gbsp_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the grid shortest-path search block.
module tb;
   import gbsp_pkg::*;

   localparam int MAX_DIM      = 128;
   localparam int CELLS        = MAX_DIM * MAX_DIM;
   localparam int HALF_PERIOD  = 6;
   localparam int SETTLE       = 8;
   localparam int HOLD_CYCLES  = 1500;
   localparam int PHASE_CELLS  = 190;
   localparam int PHASE_GRIDS  = 12;
   localparam int LIMIT_CYCLES = 1500000;
   localparam int MAX_PRINTS   = 40;

   typedef enum int {MODE_NONE, MODE_SEND, MODE_RECV, MODE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [LEN_W-1:0] path_length;
      logic             reachable;
   } path_result_type;

   typedef struct packed {
      logic                  cfg;
      logic [CSR_DATA_W-1:0] rows_v;
      logic [CSR_DATA_W-1:0] cols_v;
      cell_kind_type         kind;
      logic                  last;
      logic                  typed;
      logic [LEN_W-1:0]      path_length;
      logic                  reachable;
   } dir_row_type;

   // Directed items: cfg, rows, cols, kind, last, typed, path length, reachable.
   localparam dir_row_type DIRECTED [26] = '{
      // Reset dimensions, one-cell loads that never hold both endpoints.
      '{1'b0, 8'd0, 8'd0, KIND_START, 1'b1, 1'b1, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_GOAL,  1'b1, 1'b1, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_OPEN,  1'b1, 1'b1, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_WALL,  1'b1, 1'b1, 14'd0, 1'b0},
      // Two by two grid, the path goes round the wall.
      '{1'b1, 8'd2, 8'd2, KIND_START, 1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_OPEN,  1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_WALL,  1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_GOAL,  1'b1, 1'b1, 14'd2, 1'b1},
      // Two by two grid with the goal walled off.
      '{1'b0, 8'd0, 8'd0, KIND_START, 1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_WALL,  1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_WALL,  1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_GOAL,  1'b1, 1'b1, 14'd0, 1'b0},
      // Zero rows is taken as one, giving a one by three strip.
      '{1'b1, 8'd0, 8'd3, KIND_GOAL,  1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_OPEN,  1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_START, 1'b1, 1'b1, 14'd2, 1'b1},
      // Cells beyond the grid are ignored, a second goal among them.
      '{1'b0, 8'd0, 8'd0, KIND_START, 1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_GOAL,  1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_OPEN,  1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_WALL,  1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_GOAL,  1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_OPEN,  1'b1, 1'b1, 14'd1, 1'b1},
      // Two starts: the later one counts.
      '{1'b0, 8'd0, 8'd0, KIND_START, 1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_START, 1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_GOAL,  1'b1, 1'b1, 14'd1, 1'b1},
      // Short grid: the third cell keeps what the previous grid left there.
      '{1'b0, 8'd0, 8'd0, KIND_START, 1'b0, 1'b0, 14'd0, 1'b0},
      '{1'b0, 8'd0, 8'd0, KIND_GOAL,  1'b1, 1'b1, 14'd1, 1'b1}
   };

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_cell_kind = KIND_OPEN;
   logic                  req_last_cell = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [LEN_W-1:0]      rsp_path_length;
   logic                  rsp_reachable;
   logic                  csr_valid     = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr      = CSR_ROWS;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;

   grid_bfs_shortest_path dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cell_kind   (req_cell_kind),
      .req_last_cell   (req_last_cell),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_path_length (rsp_path_length),
      .rsp_reachable   (rsp_reachable),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #HALF_PERIOD;
      clock = 1'b0;
      #HALF_PERIOD;
   end

   // Predictor state: the maze as loaded, the search scratch and the dimensions.
   bit                    maze_wall  [CELLS];
   bit                    maze_known [CELLS];
   bit                    seen_cell  [CELLS];
   int                    hop_count  [CELLS];
   int                    frontier[$];
   int                    load_pos   = 0;
   int                    start_pos  = 0;
   int                    goal_pos   = 0;
   bit                    have_start = 1'b0;
   bit                    have_goal  = 1'b0;
   logic [CSR_DATA_W-1:0] rows_reg   = DIM_RESET;
   logic [CSR_DATA_W-1:0] cols_reg   = DIM_RESET;

   path_result_type pending_paths[$];
   int              cells_sent    = 0;
   int              grids_sent    = 0;
   int              results_seen  = 0;
   int              csr_writes    = 0;
   int              mismatches    = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_left     = 0;
   bit              hold_arm      = 1'b0;
   bit              hold_used     = 1'b0;

   // A dimension register of zero acts as one, anything above the maximum as the maximum.
   function automatic int eff_dim(logic [CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic void enter_cell(int idx, int hops);
      if (maze_wall[idx] || seen_cell[idx]) return;
      seen_cell[idx] = 1'b1;
      hop_count[idx] = hops;
      frontier.push_back(idx);
   endfunction

   // Breadth-first search from the start, neighbours tried down, right, up, left.
   function automatic path_result_type solve_maze();
      int              r, c, n, p, nd;
      path_result_type res;
      r   = eff_dim(rows_reg);
      c   = eff_dim(cols_reg);
      n   = r * c;
      res = '0;
      if (!have_start || !have_goal || start_pos >= n || goal_pos >= n) return res;
      seen_cell = '{default: 1'b0};
      frontier.delete();
      seen_cell[start_pos] = 1'b1;
      hop_count[start_pos] = 0;
      frontier.push_back(start_pos);
      while (frontier.size() != 0) begin
         p = frontier.pop_front();
         if (p == goal_pos) begin
            res.path_length = LEN_W'(hop_count[p]);
            res.reachable   = 1'b1;
            return res;
         end
         nd = (hop_count[p] >= int'(LEN_MAX)) ? int'(LEN_MAX) : hop_count[p] + 1;
         if (p / c + 1 < r) enter_cell(p + c, nd);
         if (p % c + 1 < c) enter_cell(p + 1, nd);
         if (p / c > 0) enter_cell(p - c, nd);
         if (p % c > 0) enter_cell(p - 1, nd);
      end
      return res;
   endfunction

   // Store one accepted cell; the final cell of a grid yields the search result.
   function automatic void load_cell(cell_kind_type kind, logic last,
                                     output logic has_res, output path_result_type res);
      int n;
      n = eff_dim(rows_reg) * eff_dim(cols_reg);
      if (load_pos < n && load_pos < CELLS) begin
         maze_wall[load_pos]  = (kind == KIND_WALL);
         maze_known[load_pos] = 1'b1;
         if (kind == KIND_START) begin
            start_pos  = load_pos;
            have_start = 1'b1;
         end
         if (kind == KIND_GOAL) begin
            goal_pos  = load_pos;
            have_goal = 1'b1;
         end
      end
      if (load_pos < CELLS) load_pos++;
      has_res = last;
      res     = '0;
      if (last) begin
         res        = solve_maze();
         load_pos   = 0;
         have_start = 1'b0;
         have_goal  = 1'b0;
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("ERROR: result %0d %s: got %0d, expected %0d", results_seen, what, got, want);
   endtask

   // Offer one item after a random gap and hold it until it is taken.
   task automatic send_cell(cell_kind_type kind, logic last, logic typed,
                            path_result_type want);
      logic            has_res;
      path_result_type model_res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid     <= 1'b0;
         req_cell_kind <= 2'($urandom);
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cell_kind <= kind;
      req_last_cell <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      load_cell(kind, last, has_res, model_res);
      cells_sent++;
      if (has_res) pending_paths.push_back(typed ? want : model_res);
   endtask

   // Let every outstanding result arrive and the block settle before a register write.
   task automatic write_dims(logic [CSR_DATA_W-1:0] r, logic [CSR_DATA_W-1:0] c);
      req_valid <= 1'b0;
      while (pending_paths.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= CSR_ROWS;
      csr_wdata <= r;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      rows_reg = r;
      csr_addr  <= CSR_COLS;
      csr_wdata <= c;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cols_reg = c;
      csr_valid <= 1'b0;
      csr_writes += 2;
   endtask

   // One random grid: mostly a single start and goal among random walls, the rest
   // missing endpoints, scattered kinds, overlong grids and short grids.
   task automatic send_grid(bit allow_cfg);
      int            pick, shape, wall_pct, n, s, g, k;
      bit            short_ok;
      cell_kind_type cells[$];
      if (allow_cfg && $urandom_range(0, 2) == 0) begin
         pick = $urandom_range(0, 19);
         unique case (pick)
            0:       write_dims(8'd255, 8'd1);
            1:       write_dims(8'd1, 8'd255);
            2:       write_dims(8'd128, 8'd2);
            3:       write_dims(8'd2, 8'd128);
            4:       write_dims(8'd0, 8'd0);
            default: write_dims(8'($urandom_range(0, 8)), 8'($urandom_range(1, 8)));
         endcase
      end
      n        = eff_dim(rows_reg) * eff_dim(cols_reg);
      shape    = $urandom_range(0, 99);
      wall_pct = $urandom_range(0, 40);
      for (int i = 0; i < n; i++)
         cells.push_back(cell_kind_type'(($urandom_range(0, 99) < wall_pct) ?
                                         KIND_WALL : KIND_OPEN));
      s = $urandom_range(0, n - 1);
      g = $urandom_range(0, n - 1);
      if (shape >= 78 && shape < 86) begin
         foreach (cells[i]) cells[i] = cell_kind_type'($urandom_range(0, 3));
      end else if (shape >= 70 && shape < 78) begin
         pick = $urandom_range(0, 2);
         if (pick == 0) cells[s] = KIND_START;
         if (pick == 1) cells[g] = KIND_GOAL;
      end else begin
         cells[s] = KIND_START;
         cells[g] = KIND_GOAL;
      end
      if (shape >= 86 && shape < 93) begin
         repeat ($urandom_range(1, 6)) cells.push_back(cell_kind_type'($urandom_range(0, 3)));
      end else if (shape >= 93) begin
         // Cut the grid short only where the rest of it was loaded by an earlier grid.
         k        = $urandom_range(1, n);
         short_ok = 1'b1;
         for (int i = k; i < n; i++) if (!maze_known[i]) short_ok = 1'b0;
         if (short_ok) while (cells.size() > k) void'(cells.pop_back());
      end
      foreach (cells[i]) send_cell(cells[i], i == cells.size() - 1, 1'b0, '0);
      grids_sent++;
   endtask

   // Result checker.
   always @(posedge clock) begin
      path_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_paths.size() == 0) begin
            report_mismatch("arrived with none expected", int'(rsp_path_length), 0);
         end else begin
            want = pending_paths.pop_front();
            if (rsp_path_length !== want.path_length)
               report_mismatch("path_length", int'(rsp_path_length), int'(want.path_length));
            if (rsp_reachable !== want.reachable)
               report_mismatch("reachable", int'(rsp_reachable), int'(want.reachable));
         end
      end
   end

   // The one long hold-off of the result channel, counted here in cycles.
   always @(posedge clock) begin
      if (hold_arm && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver stalls at random, or throughout the hold-off.
   always @(posedge clock) begin
      rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Stimulus.
   initial begin
      path_result_type want;
      idle_mode_type   mode;
      int              phase_cells, phase_grids;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed items.
      for (int i = 0; i < $size(DIRECTED); i++) begin
         if (DIRECTED[i].cfg) write_dims(DIRECTED[i].rows_v, DIRECTED[i].cols_v);
         want.path_length = DIRECTED[i].path_length;
         want.reachable   = DIRECTED[i].reachable;
         send_cell(DIRECTED[i].kind, DIRECTED[i].last, DIRECTED[i].typed, want);
      end

      // Hold the result channel while further grids pile up behind the first.
      write_dims(8'd6, 8'd6);
      hold_arm <= 1'b1;
      repeat (4) send_grid(1'b0);

      // Random grids under each idling pattern.
      for (int m = MODE_NONE; m <= MODE_BOTH; m++) begin
         mode = idle_mode_type'(m);
         unique case (mode)
            MODE_NONE: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
            MODE_SEND: begin
               send_idle_pct = 57;
               recv_idle_pct <= 0;
            end
            MODE_RECV: begin
               send_idle_pct = 0;
               recv_idle_pct <= 57;
            end
            default: begin
               send_idle_pct = 14;
               recv_idle_pct <= 14;
            end
         endcase
         phase_cells = cells_sent;
         phase_grids = grids_sent;
         while (cells_sent - phase_cells < PHASE_CELLS || grids_sent - phase_grids < PHASE_GRIDS)
            send_grid(1'b1);
      end

      // Drain and finish.
      req_valid <= 1'b0;
      while (pending_paths.size() != 0) @(posedge clock);
      repeat (2 * SETTLE) @(posedge clock);
      $display("Run covered %0d cells in %0d grids, %0d results checked, %0d register writes.",
               cells_sent, grids_sent, results_seen, csr_writes);
      $display("Directed corner cases, four idling patterns and one long result hold-off.");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("Timed out with %0d results outstanding.", pending_paths.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
